FILE: rtl/acfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ASCII frame checksum parser.
// No dependencies; every other file refers to this package by scoped names.
package acfp_pkg;

  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int LEN_W     = ADDR_W + 1;

  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] LOWER_A    = 8'h61;

  localparam logic [LEN_W-1:0] SUM_START = LEN_W'(3);
  localparam logic [LEN_W-1:0] PAY_START = LEN_W'(6);

  // Register index decoded from the configuration address
  localparam logic REG_HEX_LOWER = 1'b0;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic             ovf;
    logic             ok;
    logic [7:0]       id;
    logic [LEN_W-1:0] used;
    logic             has_pay;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_PUT  = 3'b100
  } back_state_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic lower);
    logic [7:0] base;
    base = lower ? LOWER_A : UPPER_A;
    if (nib < 4'd10) begin
      return ASCII_ZERO + {4'd0, nib};
    end
    return base + {4'd0, nib} - 8'd10;
  endfunction

endpackage

FILE: rtl/acfp_front.sv
`timescale 1ns / 1ps
// Front end: accepts received bytes, writes them to the frame store and
// classifies each frame at its newline into a job. Depends on acfp_pkg.
module acfp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              hex_lower,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        rx_byte,
  input  logic              fifo_full,
  input  acfp_pkg::back_stat_t back_stat,
  output logic              push,
  output acfp_pkg::job_t    job,
  output acfp_pkg::wr_t     wr
);

  logic [acfp_pkg::LEN_W-1:0] length;
  logic [acfp_pkg::LEN_W-1:0] used_cnt;
  logic                       ovf_seen;
  logic                       zero_seen;
  logic                       pay_pend;
  logic [7:0]                 sum;
  logic [7:0]                 b0, b1, b3, b4;

  logic                       take, is_nl, store, count_it;
  logic [7:0]                 e0, e1, e3, e4, sum_fin;
  logic [acfp_pkg::LEN_W-1:0] used_fin;
  logic                       ok;

  assign in_ready = !pay_pend && !fifo_full;
  assign take     = in_valid && in_ready;
  assign is_nl    = (rx_byte == acfp_pkg::NEWLINE);
  assign store    = (length < acfp_pkg::LEN_W'(acfp_pkg::MAX_FRAME));
  // Byte counts towards the used length and sum while no zero has been met
  assign count_it = store && !zero_seen && (rx_byte != 8'd0);

  assign wr.en   = take && store;
  assign wr.addr = length[acfp_pkg::ADDR_W-1:0];
  assign wr.data = rx_byte;

  always_comb begin
    e0 = (store && length == acfp_pkg::LEN_W'(0)) ? rx_byte : b0;
    e1 = (store && length == acfp_pkg::LEN_W'(1)) ? rx_byte : b1;
    e3 = (store && length == acfp_pkg::LEN_W'(3)) ? rx_byte : b3;
    e4 = (store && length == acfp_pkg::LEN_W'(4)) ? rx_byte : b4;
    used_fin = count_it ? used_cnt + acfp_pkg::LEN_W'(1) : used_cnt;
    sum_fin  = (count_it && length >= acfp_pkg::SUM_START) ? sum + rx_byte : sum;
    ok = !(ovf_seen || !store) &&
         acfp_pkg::hex_digit(sum_fin[7:4], hex_lower) == e0 &&
         acfp_pkg::hex_digit(sum_fin[3:0], hex_lower) == e1;
    job.ovf     = ovf_seen || !store;
    job.ok      = ok;
    job.id      = ok ? (((e3 - acfp_pkg::ASCII_ZERO) << 4) + e4 - acfp_pkg::ASCII_ZERO)
                     : 8'd0;
    job.used    = used_fin;
    job.has_pay = ok && (used_fin > acfp_pkg::PAY_START);
  end

  assign push = take && is_nl;

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      used_cnt  <= '0;
      ovf_seen  <= 1'b0;
      zero_seen <= 1'b0;
      pay_pend  <= 1'b0;
      sum       <= '0;
      b0        <= '0;
      b1        <= '0;
      b3        <= '0;
      b4        <= '0;
    end else begin
      if (back_stat.done) begin
        pay_pend <= 1'b0;
      end
      if (take) begin
        if (is_nl) begin
          // Frame closes: hand over the job and start afresh
          pay_pend  <= job.has_pay;
          length    <= '0;
          used_cnt  <= '0;
          ovf_seen  <= 1'b0;
          zero_seen <= 1'b0;
          sum       <= '0;
          b0        <= '0;
          b1        <= '0;
          b3        <= '0;
          b4        <= '0;
        end else if (store) begin
          length   <= length + acfp_pkg::LEN_W'(1);
          used_cnt <= used_fin;
          sum      <= sum_fin;
          b0       <= e0;
          b1       <= e1;
          b3       <= e3;
          b4       <= e4;
          if (rx_byte == 8'd0) begin
            zero_seen <= 1'b1;
          end
        end else begin
          ovf_seen <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/acfp_job_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of frame jobs between the front and back ends.
// Depends on acfp_pkg.
module acfp_job_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  acfp_pkg::job_t push_job,
  input  logic           pop,
  output acfp_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  acfp_pkg::job_t slots [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

FILE: rtl/acfp_back.sv
`timescale 1ns / 1ps
// Back end: holds the frame store, turns jobs into a verdict and payload
// transactions through a registered output. Depends on acfp_pkg.
module acfp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  acfp_pkg::wr_t        wr,
  input  acfp_pkg::job_t       head,
  input  logic                 empty,
  output logic                 pop,
  output acfp_pkg::back_stat_t back_stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 item_kind,
  output logic                 checksum_ok,
  output logic                 frame_overflow,
  output logic [7:0]           packet_id,
  output logic [7:0]           payload_byte,
  output logic                 last_item
);

  logic [7:0]                 store_mem [acfp_pkg::MAX_FRAME];
  logic [7:0]                 rd_data;
  acfp_pkg::back_state_t      state;
  logic [acfp_pkg::LEN_W-1:0] idx;
  logic [acfp_pkg::LEN_W-1:0] used;
  logic                       slot_free, is_last, load_out;

  assign slot_free      = !out_valid || out_ready;
  assign pop            = (state == acfp_pkg::B_IDLE) && !empty && slot_free;
  assign load_out       = pop || ((state == acfp_pkg::B_PUT) && slot_free);
  assign is_last        = (idx + acfp_pkg::LEN_W'(1) == used);
  assign back_stat.busy = (state != acfp_pkg::B_IDLE);
  assign back_stat.done = (state == acfp_pkg::B_PUT) && slot_free && is_last;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_mem[wr.addr] <= wr.data;
    end
    if (state == acfp_pkg::B_READ) begin
      rd_data <= store_mem[idx[acfp_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= acfp_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        acfp_pkg::B_IDLE: begin
          if (pop && head.has_pay) begin
            state <= acfp_pkg::B_READ;
          end
        end
        acfp_pkg::B_READ: begin
          state <= acfp_pkg::B_PUT;
        end
        acfp_pkg::B_PUT: begin
          if (slot_free) begin
            state <= is_last ? acfp_pkg::B_IDLE : acfp_pkg::B_READ;
          end
        end
        default: begin
          state <= acfp_pkg::B_IDLE;
        end
      endcase
    end
  end

  // Output fields and the walk through the payload
  always_ff @(posedge clk) begin
    if (pop) begin
      item_kind      <= 1'b0;
      checksum_ok    <= head.ok;
      frame_overflow <= head.ovf;
      packet_id      <= head.id;
      payload_byte   <= 8'd0;
      last_item      <= !head.has_pay;
      idx            <= acfp_pkg::PAY_START;
      used           <= head.used;
    end else if (state == acfp_pkg::B_PUT && slot_free) begin
      item_kind      <= 1'b1;
      checksum_ok    <= 1'b0;
      frame_overflow <= 1'b0;
      packet_id      <= 8'd0;
      payload_byte   <= rd_data;
      last_item      <= is_last;
      idx            <= idx + acfp_pkg::LEN_W'(1);
    end
  end

endmodule

FILE: rtl/ascii_frame_checksum_parser.sv
`timescale 1ns / 1ps
// Top level of the ASCII frame checksum parser: configuration register,
// front end, job queue and back end. Depends on acfp_pkg and all acfp_ modules.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  input     in_valid / in_ready    rx_byte
//  output    out_valid / out_ready  item_kind, checksum_ok, frame_overflow,
//                                   packet_id, payload_byte, last_item
//  config    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// Bytes are taken one per cycle; a newline closes the frame and its verdict
// is loaded into the output register at the edge where its job leaves the
// queue (later while earlier results wait). Each payload byte takes a
// frame-store read and then an output load.
// Input stalls while a payload drains (the frame store has one write and one
// read port and holds only one frame) or while the two-entry job queue is full.
// Reset (rst, synchronous) clears control state; the frame store is not cleared.
module ascii_frame_checksum_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic        checksum_ok,
  output logic        frame_overflow,
  output logic [7:0]  packet_id,
  output logic [7:0]  payload_byte,
  output logic        last_item
);

  logic                 hex_lower;
  logic                 push, pop, fifo_empty, fifo_full;
  acfp_pkg::job_t       push_job, head;
  acfp_pkg::wr_t        wr;
  acfp_pkg::back_stat_t back_stat;

  // Configuration: one register, hex letter case, decoded at byte addresses 0 to 3 (paddr[2] low)
  assign pready = 1'b1;
  assign prdata = (paddr[2] == acfp_pkg::REG_HEX_LOWER) ? {31'd0, hex_lower} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_lower <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == acfp_pkg::REG_HEX_LOWER) begin
      hex_lower <= pwdata[0];
    end
  end

  // Accept and classify bytes, write the frame store
  acfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hex_lower (hex_lower),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .fifo_full (fifo_full),
    .back_stat (back_stat),
    .push      (push),
    .job       (push_job),
    .wr        (wr)
  );

  // Hold finished frame jobs until the back end is free
  acfp_job_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  // Emit verdicts and drain payloads from the frame store
  acfp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .head           (head),
    .empty          (fifo_empty),
    .pop            (pop),
    .back_stat      (back_stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .checksum_ok    (checksum_ok),
    .frame_overflow (frame_overflow),
    .packet_id      (packet_id),
    .payload_byte   (payload_byte),
    .last_item      (last_item)
  );

`ifndef SYNTHESIS
  // The frame store must not take new bytes while a payload is being read
  a_no_accept_draining: assert property (@(posedge clk) disable iff (rst)
    back_stat.busy |-> !in_ready)
    else $error("input accepted while payload drains");

  // An overflow verdict is always alone and never passes the checksum
  a_overflow_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_overflow) |-> (last_item && !checksum_ok && !item_kind))
    else $error("malformed overflow verdict");

  // Finishing a drain loads the final payload transaction
  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    back_stat.done |=> (out_valid && item_kind && last_item))
    else $error("drain finished without a last payload transaction");
`endif

endmodule
